// File: rtl/yuv_color_tolerance_mask_defines.svh
// -----------------------------------------------------------------------------
// yuv_color_tolerance_mask_defines.svh
// Assertion macros shared by the color key mask RTL.
// -----------------------------------------------------------------------------
`ifndef YUV_COLOR_TOLERANCE_MASK_DEFINES_SVH
`define YUV_COLOR_TOLERANCE_MASK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YCTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("yctm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define YCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("yctm assertion failed");

`endif

// File: rtl/yctm_pkg.sv
// -----------------------------------------------------------------------------
// yctm_pkg
// Types and constants of the color key mask chain.
// -----------------------------------------------------------------------------
package yctm_pkg;

    localparam int MAX_COLORS = 16;
    localparam int CELL_IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    localparam int SAMPLE_W = 16;
    localparam int TOL_W    = 16;
    localparam int ACT_W    = 5;
    localparam int ENTRY_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Width that holds a cell number, an entry index and the active count.
    localparam int CMP_W = (CELL_IDX_W > ACT_W) ? CELL_IDX_W : ACT_W;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_TOL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE       = 2'd3;

    localparam logic [SAMPLE_W-1:0] FULL_NARROW = 16'h00FF;
    localparam logic [SAMPLE_W-1:0] FULL_WIDE   = 16'hFFFF;

    localparam logic [TOL_W-1:0] LUMA_TOL_RST   = 16'd10;
    localparam logic [TOL_W-1:0] CHROMA_TOL_RST = 16'd5;

    typedef struct packed {
        logic [TOL_W-1:0] luma_tol;
        logic [TOL_W-1:0] chroma_tol;
        logic [ACT_W-1:0] active;
        logic             wide;
    } t_cfg;

    // Word handed from cell to cell.
    typedef struct packed {
        logic                valid;
        logic                mode;
        logic [ENTRY_W-1:0]  idx;
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] u;
        logic [SAMPLE_W-1:0] v;
        logic                hit_y;
        logic                hit_u;
        logic                hit_v;
    } t_cell_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] u;
        logic [SAMPLE_W-1:0] v;
    } t_color;

    function automatic logic [SAMPLE_W-1:0] abs_gap(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
        abs_gap = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: rtl/yctm_pix_if.sv
// -----------------------------------------------------------------------------
// yctm_pix_if
// Input channel: table load or pixel word with valid/ready handshake.
// -----------------------------------------------------------------------------
interface yctm_pix_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  entry_index;
    logic [15:0] luma;
    logic [15:0] chroma_u;
    logic [15:0] chroma_v;

    modport source (output valid, mode, entry_index, luma, chroma_u, chroma_v,
                    input ready);
    modport sink   (input valid, mode, entry_index, luma, chroma_u, chroma_v,
                    output ready);
endinterface

// File: rtl/yctm_mask_if.sv
// -----------------------------------------------------------------------------
// yctm_mask_if
// Output channel: one mask sample per classified pixel.
// -----------------------------------------------------------------------------
interface yctm_mask_if;
    logic        valid;
    logic        ready;
    logic [15:0] mask;

    modport source (output valid, mask, input ready);
    modport sink   (input valid, mask, output ready);
endinterface

// File: rtl/yctm_cell.sv
// -----------------------------------------------------------------------------
// yctm_cell
// One key color entry plus one pipeline stage of the compare chain.
// -----------------------------------------------------------------------------
module yctm_cell import yctm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_cfg                  i_cfg,
    input  logic [CELL_IDX_W-1:0] i_cell_idx,
    input  t_cell_word            i_word,
    output t_cell_word            o_word
);

    t_color     r_entry;
    t_cell_word r_word;
    t_cell_word n_word;

    logic [CMP_W-1:0]    cell_ext;
    logic                enabled;
    logic                wr_hit;
    logic [SAMPLE_W-1:0] smask;
    logic [SAMPLE_W-1:0] py, pu, pv, cy, cu, cv;

    always_comb begin
        cell_ext = CMP_W'(i_cell_idx);
        enabled  = cell_ext < CMP_W'(i_cfg.active);
        wr_hit   = i_adv && i_word.valid && (i_word.mode == MODE_LOAD)
                   && (CMP_W'(i_word.idx) == cell_ext);
        smask    = i_cfg.wide ? FULL_WIDE : FULL_NARROW;
        py = i_word.y & smask;
        pu = i_word.u & smask;
        pv = i_word.v & smask;
        cy = r_entry.y & smask;
        cu = r_entry.u & smask;
        cv = r_entry.v & smask;

        // Fold this entry's match into the flags carried by the word.
        n_word = i_word;
        n_word.hit_y = i_word.hit_y || (enabled && (abs_gap(py, cy) < i_cfg.luma_tol));
        n_word.hit_u = i_word.hit_u || (enabled && (abs_gap(pu, cu) < i_cfg.chroma_tol));
        n_word.hit_v = i_word.hit_v || (enabled && (abs_gap(pv, cv) < i_cfg.chroma_tol));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry      <= '0;
            r_word.valid <= 1'b0;
        end else begin
            if (wr_hit) begin
                r_entry.y <= i_word.y;
                r_entry.u <= i_word.u;
                r_entry.v <= i_word.v;
            end
            if (i_adv) begin
                r_word <= n_word;
            end
        end
    end

    assign o_word = r_word;

endmodule

// File: rtl/yuv_color_tolerance_mask.sv
// -----------------------------------------------------------------------------
// yuv_color_tolerance_mask
// YUV color key mask: a chain of key color cells classifies each pixel.
// -----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  i_pix     in   valid/ready        mode, entry_index, luma, chroma_u, chroma_v
//  o_mask    out  valid/ready        mask
//  cfg       in   i_cfg_we (no wait) i_cfg_idx, i_cfg_data
//
//  One word is accepted per cycle unless the chain holds. Each word walks the
//  chain of MAX_COLORS cells, one cell per cycle while the chain advances, starting
//  at the accepting edge, then a mask lands in the output register.
//  Table loads update their cell as they pass it and give no output. Synchronous
//  active-low reset clears the table and all valid bits and sets the configuration
//  to its reset values. The whole chain holds only when a pixel reaches the end
//  while the output register is full and not taken.
//
module yuv_color_tolerance_mask import yctm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    yctm_pix_if.sink              i_pix,
    yctm_mask_if.source           o_mask
);

`include "yuv_color_tolerance_mask_defines.svh"

    t_cfg r_cfg;

    // Configuration writes; indexes past the list do nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_tol   <= LUMA_TOL_RST;
            r_cfg.chroma_tol <= CHROMA_TOL_RST;
            r_cfg.active     <= '0;
            r_cfg.wide       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LUMA_TOL:   r_cfg.luma_tol   <= i_cfg_data;
                CFG_CHROMA_TOL: r_cfg.chroma_tol <= i_cfg_data;
                CFG_ACTIVE:     r_cfg.active     <= i_cfg_data[ACT_W-1:0];
                CFG_WIDE:       r_cfg.wide       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    t_cell_word chain [MAX_COLORS+1];
    logic       adv;
    logic       last_pix;
    logic       load_out;

    // Chain head: a fresh word starts with no hits; an idle input is a bubble.
    always_comb begin
        chain[0].valid = i_pix.valid;
        chain[0].mode  = i_pix.mode;
        chain[0].idx   = i_pix.entry_index;
        chain[0].y     = i_pix.luma;
        chain[0].u     = i_pix.chroma_u;
        chain[0].v     = i_pix.chroma_v;
        chain[0].hit_y = 1'b0;
        chain[0].hit_u = 1'b0;
        chain[0].hit_v = 1'b0;
    end

    for (genvar k = 0; k < MAX_COLORS; k++) begin : g_cell
        yctm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_cfg      (r_cfg),
            .i_cell_idx (CELL_IDX_W'(k)),
            .i_word     (chain[k]),
            .o_word     (chain[k+1])
        );
    end

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_mask;
    logic                n_out_valid;

    // Hold the chain only when a finished pixel has nowhere to go.
    always_comb begin
        last_pix = chain[MAX_COLORS].valid && (chain[MAX_COLORS].mode == MODE_CLASSIFY);
        adv      = !(last_pix && r_out_valid && !o_mask.ready);
        load_out = adv && last_pix;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_mask.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // AND the per-channel flags and drive the full-scale value or zero.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mask <= (chain[MAX_COLORS].hit_y && chain[MAX_COLORS].hit_u
                           && chain[MAX_COLORS].hit_v)
                          ? (r_cfg.wide ? FULL_WIDE : FULL_NARROW) : '0;
        end
    end

    assign i_pix.ready  = adv;
    assign o_mask.valid = r_out_valid;
    assign o_mask.mask  = r_out_mask;

    // A pixel stuck at the chain end must block new input.
    `YCTM_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        last_pix && r_out_valid && !o_mask.ready, !i_pix.ready)
    // A taken mask with nothing behind it leaves the output empty.
    `YCTM_ASSERT_NEXT(a_taken_clears, i_clk, i_rst_n,
        o_mask.valid && o_mask.ready && !last_pix, !o_mask.valid)
    // A pending pixel at the chain end with a free slot is always loaded.
    `YCTM_ASSERT_NEXT(a_free_slot_loads, i_clk, i_rst_n,
        last_pix && !r_out_valid, o_mask.valid)
    // The mask is only ever zero or a full-scale value.
    `YCTM_ASSERT_NOW(a_mask_levels, i_clk, i_rst_n,
        o_mask.valid,
        (o_mask.mask == '0) || (o_mask.mask == FULL_NARROW) || (o_mask.mask == FULL_WIDE))

endmodule

// File: test/tb.sv
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the YUV color key mask. Key color loads and pixel
// words go in over the pixel channel with random gaps, and each mask sample that
// comes out is checked against an in-bench key table model. The configuration
// changes only between phases, once the chain has drained.
// -----------------------------------------------------------------------------
module tb;
    import yctm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    // Chain length plus the output register, with margin, for loads in flight.
    localparam int DRAIN_CYCLES = MAX_COLORS + 8;

    typedef struct packed {
        logic                mode;
        logic [ENTRY_W-1:0]  idx;
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] u;
        logic [SAMPLE_W-1:0] v;
    } t_pix_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    yctm_pix_if  pix_if ();
    yctm_mask_if mask_if ();

    yuv_color_tolerance_mask u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_mask     (mask_if)
    );

    // Words waiting to be sent, and mask samples waiting to come out.
    t_pix_word           word_q[$];
    logic [SAMPLE_W-1:0] mask_exp_q[$];

    // Key table as the block should see it, advanced as words are accepted, and
    // the configuration as last written.
    logic [SAMPLE_W-1:0] key_y [MAX_COLORS];
    logic [SAMPLE_W-1:0] key_u [MAX_COLORS];
    logic [SAMPLE_W-1:0] key_v [MAX_COLORS];
    logic [TOL_W-1:0]    tol_luma;
    logic [TOL_W-1:0]    tol_chroma;
    logic [ACT_W-1:0]    act_cnt;
    logic                wide_sel;

    // Key table as planned by the stimulus, advanced as loads are queued.
    logic [SAMPLE_W-1:0] plan_y [MAX_COLORS];
    logic [SAMPLE_W-1:0] plan_u [MAX_COLORS];
    logic [SAMPLE_W-1:0] plan_v [MAX_COLORS];

    int   err_cnt;
    int   cyc;
    logic calm;   // high: neither side idles

    always #5 i_clk = ~i_clk;

    function automatic logic [SAMPLE_W-1:0] sample_gap(input logic [SAMPLE_W-1:0] a,
                                                       input logic [SAMPLE_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Mask sample for one pixel against the enabled key colors.
    function automatic logic [SAMPLE_W-1:0] key_mask(input t_pix_word w);
        logic [SAMPLE_W-1:0] smask;
        logic                hy, hu, hv;
        int                  n;
        int                  i;
        smask = wide_sel ? FULL_WIDE : FULL_NARROW;
        hy = 1'b0;
        hu = 1'b0;
        hv = 1'b0;
        n = (act_cnt > MAX_COLORS) ? MAX_COLORS : int'(act_cnt);
        for (i = 0; i < n; i++) begin
            if (sample_gap(w.y & smask, key_y[i] & smask) < tol_luma)   hy = 1'b1;
            if (sample_gap(w.u & smask, key_u[i] & smask) < tol_chroma) hu = 1'b1;
            if (sample_gap(w.v & smask, key_v[i] & smask) < tol_chroma) hv = 1'b1;
        end
        return (hy && hu && hv) ? smask : '0;
    endfunction

    task automatic note_miss(input string what, input logic [SAMPLE_W-1:0] exp_mask,
                             input logic [SAMPLE_W-1:0] act_mask);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch: %s, expected mask %h, got %h", what, exp_mask, act_mask);
    endtask

    // Driver: hold a word until it is taken, then advance to the next one.
    always @(posedge i_clk) begin
        t_pix_word w;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                w.mode = pix_if.mode;
                w.idx  = pix_if.entry_index;
                w.y    = pix_if.luma;
                w.u    = pix_if.chroma_u;
                w.v    = pix_if.chroma_v;
                if (w.mode == MODE_LOAD) begin
                    key_y[w.idx] = w.y;
                    key_u[w.idx] = w.u;
                    key_v[w.idx] = w.v;
                end else begin
                    mask_exp_q.push_back(key_mask(w));
                end
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (word_q.size() > 0 && $urandom_range(0, 99) >= (calm ? 0 : 8)) begin
                    w = word_q.pop_front();
                    pix_if.valid       <= 1'b1;
                    pix_if.mode        <= w.mode;
                    pix_if.entry_index <= w.idx;
                    pix_if.luma        <= w.y;
                    pix_if.chroma_u    <= w.u;
                    pix_if.chroma_v    <= w.v;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and check every mask word taken.
    always @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] exp_mask;
        if (!i_rst_n) begin
            mask_if.ready <= 1'b0;
        end else begin
            if (mask_if.valid && mask_if.ready) begin
                if (mask_exp_q.size() == 0) begin
                    note_miss("mask word with no pixel pending", '0, mask_if.mask);
                end else begin
                    exp_mask = mask_exp_q.pop_front();
                    if (mask_if.mask !== exp_mask)
                        note_miss("mask value", exp_mask, mask_if.mask);
                end
            end
            mask_if.ready <= ($urandom_range(0, 99) >= (calm ? 0 : 8));
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Write one register and mirror it into the model configuration.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_LUMA_TOL:   tol_luma   = data;
            CFG_CHROMA_TOL: tol_chroma = data;
            CFG_ACTIVE:     act_cnt    = data[ACT_W-1:0];
            CFG_WIDE:       wide_sel   = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_load(input int idx, input logic [SAMPLE_W-1:0] y,
                             input logic [SAMPLE_W-1:0] u, input logic [SAMPLE_W-1:0] v);
        t_pix_word w;
        w.mode = MODE_LOAD;
        w.idx  = idx[ENTRY_W-1:0];
        w.y    = y;
        w.u    = u;
        w.v    = v;
        plan_y[idx] = y;
        plan_u[idx] = u;
        plan_v[idx] = v;
        word_q.push_back(w);
    endtask

    task automatic push_pix(input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] u,
                            input logic [SAMPLE_W-1:0] v);
        t_pix_word w;
        w.mode = MODE_CLASSIFY;
        w.idx  = ENTRY_W'($urandom_range(0, MAX_COLORS - 1));
        w.y    = y;
        w.u    = u;
        w.v    = v;
        word_q.push_back(w);
    endtask

    // Wait until every word is sent and every mask is in, then let loads leave
    // the chain. Sample on the falling edge so the driver's updates have settled.
    task automatic drain();
        while (word_q.size() > 0 || pix_if.valid || mask_exp_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sample close to a key sample, so that the tolerance edge gets hit.
    function automatic logic [SAMPLE_W-1:0] near_sample(input logic [SAMPLE_W-1:0] base,
                                                        input logic [TOL_W-1:0] tol);
        int                  sp;
        int                  off;
        logic [SAMPLE_W-1:0] s;
        sp  = (tol > 300) ? 300 : int'(tol) + 2;
        off = int'($urandom_range(0, 2 * sp)) - sp;
        s   = base + off[SAMPLE_W-1:0];
        if (!wide_sel)
            s[15:8] = 8'($urandom_range(0, 255));
        return s;
    endfunction

    function automatic logic [TOL_W-1:0] pick_tol();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            3:       return TOL_W'($urandom_range(0, 65535));
            default: return TOL_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_active();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ACT_W'(MAX_COLORS);
            2:       return ACT_W'($urandom_range(MAX_COLORS + 1, 31));
            default: return ACT_W'($urandom_range(1, MAX_COLORS));
        endcase
    endfunction

    // One random word: mostly loads and pixels close to a live key color,
    // the rest plain noise.
    task automatic push_random();
        int r;
        int k;
        int n;
        r = $urandom_range(0, 99);
        n = (act_cnt > MAX_COLORS) ? MAX_COLORS : int'(act_cnt);
        k = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, MAX_COLORS - 1);
        if (r < 20) begin
            push_load($urandom_range(0, MAX_COLORS - 1), SAMPLE_W'($urandom_range(0, 65535)),
                      SAMPLE_W'($urandom_range(0, 65535)),
                      SAMPLE_W'($urandom_range(0, 65535)));
        end else if (r < 32) begin
            push_pix(SAMPLE_W'($urandom_range(0, 65535)), SAMPLE_W'($urandom_range(0, 65535)),
                     SAMPLE_W'($urandom_range(0, 65535)));
        end else begin
            push_pix(near_sample(plan_y[k], tol_luma), near_sample(plan_u[k], tol_chroma),
                     near_sample(plan_v[k], tol_chroma));
        end
    endtask

    initial begin
        int i;
        int ph;
        i_clk    = 1'b0;
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        pix_if.valid       = 1'b0;
        pix_if.mode        = MODE_LOAD;
        pix_if.entry_index = '0;
        pix_if.luma        = '0;
        pix_if.chroma_u    = '0;
        pix_if.chroma_v    = '0;
        mask_if.ready      = 1'b0;
        err_cnt    = 0;
        cyc        = 0;
        calm       = 1'b0;
        tol_luma   = LUMA_TOL_RST;
        tol_chroma = CHROMA_TOL_RST;
        act_cnt    = '0;
        wide_sel   = 1'b0;
        for (i = 0; i < MAX_COLORS; i++) begin
            key_y[i]  = '0;
            key_u[i]  = '0;
            key_v[i]  = '0;
            plan_y[i] = '0;
            plan_u[i] = '0;
            plan_v[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: no active colors, so nothing matches.
        push_pix(16'h0000, 16'h0000, 16'h0000);
        push_load(0, 16'h1234, 16'h5680, 16'h9AFF);
        push_load(MAX_COLORS - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        // One color, narrow samples: high bytes drop out, tolerance edge.
        write_reg(CFG_ACTIVE, 16'd1);
        push_pix(16'hFF34, 16'h0080, 16'h00FF);
        push_pix(16'h003D, 16'h0084, 16'h00FB);
        push_pix(16'h003E, 16'h0085, 16'h00FA);
        drain();

        // Wide samples, full table.
        write_reg(CFG_WIDE, 16'd1);
        write_reg(CFG_ACTIVE, CFG_DATA_W'(MAX_COLORS));
        push_pix(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pix(16'h1234, 16'h5680, 16'h9AFF);
        push_pix(16'h0000, 16'h0000, 16'h0000);
        push_pix(16'hFF34, 16'h5680, 16'h9AFF);
        drain();

        // Zero luma tolerance never matches.
        write_reg(CFG_LUMA_TOL, 16'd0);
        push_pix(16'h1234, 16'h5680, 16'h9AFF);
        drain();

        // Widest tolerances and an active count past the table.
        write_reg(CFG_LUMA_TOL, 16'hFFFF);
        write_reg(CFG_CHROMA_TOL, 16'hFFFF);
        write_reg(CFG_ACTIVE, 16'd31);
        push_pix(16'h8000, 16'h8000, 16'h8000);
        drain();

        // Zero chroma tolerance never matches.
        write_reg(CFG_CHROMA_TOL, 16'd0);
        push_pix(16'h1234, 16'h5680, 16'h9AFF);
        drain();

        // Narrow samples with tolerances above 255: any difference matches.
        write_reg(CFG_WIDE, 16'd0);
        write_reg(CFG_LUMA_TOL, 16'd256);
        write_reg(CFG_CHROMA_TOL, 16'd300);
        write_reg(CFG_ACTIVE, 16'd1);
        push_pix(16'hABCD, 16'h0001, 16'hFE00);
        drain();

        // Load a color and classify against it right behind the load.
        write_reg(CFG_LUMA_TOL, 16'd10);
        write_reg(CFG_CHROMA_TOL, 16'd5);
        write_reg(CFG_ACTIVE, 16'd2);
        push_load(1, 16'h00AA, 16'h00BB, 16'h00CC);
        push_pix(16'h00AA, 16'h00BB, 16'h00CC);
        push_pix(16'h00A1, 16'h00B7, 16'h00C8);

        // Random phases, each with its own configuration.
        for (ph = 0; ph < 10; ph++) begin
            drain();
            calm <= (ph == 4);
            write_reg(CFG_LUMA_TOL, pick_tol());
            write_reg(CFG_CHROMA_TOL, pick_tol());
            write_reg(CFG_ACTIVE, CFG_DATA_W'(pick_active()));
            write_reg(CFG_WIDE, CFG_DATA_W'($urandom_range(0, 1)));
            repeat (105) push_random();
        end
        drain();

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: yuv_color_tolerance_mask.f
+incdir+rtl
rtl/yctm_pkg.sv
rtl/yctm_pix_if.sv
rtl/yctm_mask_if.sv
rtl/yctm_cell.sv
rtl/yuv_color_tolerance_mask.sv
test/tb.sv
